/* rtl/srde_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srde_pkg
// Shared types and constants of the signed radix digit emitter.
// ----------------------------------------------------------------------------
package srde_pkg;

    localparam int MAX_SYMBOLS_DFLT = 16;
    localparam int SYM_COUNT        = 16;
    localparam int SYM_IDX_W        = 4;
    localparam int SYM_W            = 8;
    localparam int RADIX_W          = 5;
    localparam int VALUE_W          = 32;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 64;
    localparam int DIGIT_DEPTH      = 32;
    localparam int DIGIT_IDX_W      = 5;
    localparam int DIGIT_CNT_W      = 6;
    localparam int DIV_BITS         = 8;
    localparam int DIV_STEPS        = VALUE_W / DIV_BITS;
    localparam int DIV_CNT_W        = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIX        = 2'd2;

    localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    typedef struct packed {
        logic load;
        logic chk_step;
        logic div_step;
        logic emit_sign;
        logic emit_digit;
    } dp_cmd_t;

    typedef struct packed {
        logic chk_bad;
        logic chk_last;
        logic div_last;
        logic div_end;
        logic neg;
        logic out_free;
        logic digit_last;
    } dp_sts_t;

endpackage
`default_nettype wire

/* rtl/srde_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srde_if
// Channel interfaces: input values, output characters, register writes.
// ----------------------------------------------------------------------------
interface srde_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface srde_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       last;

    modport source (output valid, output char_out, output last, input ready);
    modport sink   (input valid, input char_out, input last, output ready);
endinterface

interface srde_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/signed_radix_digit_emitter_top.sv */
// Flow: accept the value, check the alphabet symbol by symbol, extract each digit
// in the 8-bit-per-cycle radix divider, emit a sign if negative, then one character
// per cycle while the output is not stalled. Throughput: one value at a time; the
// next value is taken only once the last character is in the output register.
// An invalid alphabet ends the transaction after the check with no output. Reset:
// asynchronous, active low; control regs clear, data regs and digit store do not.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_radix_digit_emitter_top
// Writes signed 32-bit values as text in a configurable radix and alphabet.
// ----------------------------------------------------------------------------
module signed_radix_digit_emitter_top
    import srde_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DFLT
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    srde_cfg_if.sink   cfg_ch,
    srde_in_if.sink    in_ch,
    srde_out_if.source out_ch
);

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    in_ready;

    assign in_ch.ready = in_ready;

    srde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    srde_dp #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .value  (in_ch.value),
        .out_ch (out_ch),
        .cmd    (cmd),
        .sts    (sts)
    );

endmodule
`default_nettype wire

/* rtl/srde_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srde_ctrl
// Sequencer: alphabet check, digit extraction, sign and digit emission.
// ----------------------------------------------------------------------------
module srde_ctrl
    import srde_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.chk_bad)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.chk_last)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (sts.div_last && sts.div_end)
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                if (!sts.neg || sts.out_free)
                begin
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (sts.out_free && sts.digit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = (state_reg == ST_IDLE);
        cmd.load       = (state_reg == ST_IDLE) && in_valid;
        cmd.chk_step   = (state_reg == ST_CHECK);
        cmd.div_step   = (state_reg == ST_DIVIDE);
        cmd.emit_sign  = (state_reg == ST_SIGN) && sts.neg && sts.out_free;
        cmd.emit_digit = (state_reg == ST_DIGITS) && sts.out_free;
    end

endmodule
`default_nettype wire

/* rtl/srde_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srde_dp
// Datapath: registers, alphabet checker, radix divider, digit store, output.
// ----------------------------------------------------------------------------
module srde_dp
    import srde_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DFLT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    srde_cfg_if.sink                cfg_ch,
    input  wire logic signed [31:0] value,
    srde_out_if.source              out_ch,
    input  wire dp_cmd_t            cmd,
    output dp_sts_t                 sts
);

    logic [CFG_DATA_W-1:0]  sym_low_reg;
    logic [CFG_DATA_W-1:0]  sym_high_reg;
    logic [RADIX_W-1:0]     radix_reg;

    logic [SYM_W-1:0]       sym [SYM_COUNT];
    logic [SYM_IDX_W-1:0]   chk_idx_reg;
    logic                   neg_reg;
    logic [VALUE_W-1:0]     mag_reg;
    logic [VALUE_W-1:0]     mag_next;
    logic [SYM_IDX_W-1:0]   rem_reg;
    logic [SYM_IDX_W-1:0]   rem_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg;
    logic [DIGIT_CNT_W-1:0] ndig_reg;
    logic [DIGIT_CNT_W-1:0] ndig_m1;
    logic [SYM_IDX_W-1:0]   digit_mem [DIGIT_DEPTH];

    logic                   out_valid_reg;
    logic [SYM_W-1:0]       char_reg;
    logic                   last_reg;

    logic [VALUE_W-1:0]     value_u;
    logic                   radix_bad;
    logic                   sign_bad;
    logic                   dup_bad;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_low_reg  <= '0;
            sym_high_reg <= '0;
            radix_reg    <= '0;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_SYMBOLS_LOW:  sym_low_reg  <= cfg_ch.data;
                REG_SYMBOLS_HIGH: sym_high_reg <= cfg_ch.data;
                REG_RADIX:        radix_reg    <= cfg_ch.data[RADIX_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        for (int k = 0; k < SYM_COUNT / 2; k++)
        begin
            sym[k]                 = sym_low_reg[k*SYM_W +: SYM_W];
            sym[k + SYM_COUNT / 2] = sym_high_reg[k*SYM_W +: SYM_W];
        end
    end

    always_comb
    begin
        radix_bad = (radix_reg < RADIX_W'(2)) || (radix_reg > RADIX_W'(MAX_SYMBOLS));
        sign_bad  = (sym[chk_idx_reg] == CHAR_PLUS) || (sym[chk_idx_reg] == CHAR_MINUS);
        dup_bad   = 1'b0;
        for (int j = 0; j < SYM_COUNT; j++)
        begin
            if ((RADIX_W'(j) > {1'b0, chk_idx_reg}) && (RADIX_W'(j) < radix_reg)
                && (sym[j] == sym[chk_idx_reg]))
            begin
                dup_bad = 1'b1;
            end
        end
    end

    always_comb
    begin
        logic [RADIX_W-1:0] t;
        logic [VALUE_W-1:0] q;
        logic [SYM_IDX_W-1:0] r;
        r = rem_reg;
        q = mag_reg;
        for (int b = 0; b < DIV_BITS; b++)
        begin
            t = {r, q[VALUE_W-1]};
            q = {q[VALUE_W-2:0], 1'b0};
            if (t >= radix_reg)
            begin
                t    = t - radix_reg;
                q[0] = 1'b1;
            end
            r = t[SYM_IDX_W-1:0];
        end
        mag_next = q;
        rem_next = r;
    end

    assign value_u = value;
    assign ndig_m1 = ndig_reg - DIGIT_CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_idx_reg <= '0;
            div_cnt_reg <= '0;
            ndig_reg    <= '0;
            neg_reg     <= 1'b0;
        end
        else if (cmd.load)
        begin
            chk_idx_reg <= '0;
            div_cnt_reg <= '0;
            ndig_reg    <= '0;
            neg_reg     <= value_u[VALUE_W-1];
        end
        else
        begin
            if (cmd.chk_step)
            begin
                chk_idx_reg <= chk_idx_reg + SYM_IDX_W'(1);
            end
            if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                if (sts.div_last)
                begin
                    ndig_reg <= ndig_reg + DIGIT_CNT_W'(1);
                end
            end
            else if (cmd.emit_digit)
            begin
                ndig_reg <= ndig_m1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg <= value_u[VALUE_W-1] ? (VALUE_W'(0) - value_u) : value_u;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            mag_reg <= mag_next;
            rem_reg <= sts.div_last ? '0 : rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_step && sts.div_last)
        begin
            digit_mem[ndig_reg[DIGIT_IDX_W-1:0]] <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_sign || cmd.emit_digit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_sign)
        begin
            char_reg <= CHAR_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= sym[digit_mem[ndig_m1[DIGIT_IDX_W-1:0]]];
            last_reg <= (ndig_reg == DIGIT_CNT_W'(1));
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.char_out = char_reg;
    assign out_ch.last     = last_reg;

    always_comb
    begin
        sts.chk_bad    = radix_bad || sign_bad || dup_bad;
        sts.chk_last   = ({1'b0, chk_idx_reg} == (radix_reg - RADIX_W'(1)));
        sts.div_last   = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
        sts.div_end    = (mag_next == '0) || (ndig_reg == DIGIT_CNT_W'(DIGIT_DEPTH - 1));
        sts.neg        = neg_reg;
        sts.out_free   = !out_valid_reg || out_ch.ready;
        sts.digit_last = (ndig_reg == DIGIT_CNT_W'(1));
    end

endmodule
`default_nettype wire

/* rtl/srde_chk.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srde_chk
// Port-level checks of the emitter, bound to the top level.
// ----------------------------------------------------------------------------
module srde_chk
    import srde_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] char_out,
    input wire logic       last
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after an accepted transaction");

    a_minus_never_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !((char_out == CHAR_MINUS) && last))
        else $error("minus sign marked as final character");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(char_out) && $stable(last)))
        else $error("stalled output transaction changed");

    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("output transaction dropped without handshake");

endmodule

bind signed_radix_digit_emitter_top srde_chk u_srde_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .char_out  (out_ch.char_out),
    .last      (out_ch.last)
);
`default_nettype wire
